/* rtl/lpw_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// lpw_pkg
// Types, register indexes and lookup tables shared by the pixel bus writer.
// ============================================================================
package lpw_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SKIP_OPCODE = 8'hFF;
    localparam logic [3:0] PACKED_WORDS = 4'd10;
    localparam logic [3:0] BYTE_WORDS   = 4'd6;

    typedef enum logic [2:0] {
        REG_BUS_16BIT,
        REG_PIXEL_18BIT,
        REG_BYTE_COORD,
        REG_ALL_COMMAND,
        REG_ROTATION,
        REG_COLUMN_OFFSET,
        REG_ROW_OFFSET,
        REG_WINDOW_OPCODES
    } cfg_reg_t;

    typedef enum logic {
        CMD_WINDOW = 1'b0,
        CMD_PIXEL  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        JOB_PACKED,
        JOB_BYTE,
        JOB_PIX16,
        JOB_PIX8,
        JOB_PIX18
    } job_mode_t;

    typedef struct packed {
        logic        bus_is_16bit;
        logic        pixel_is_18bit;
        logic        byte_coordinate_mode;
        logic        all_command_mode;
        logic [1:0]  rotation;
        logic [15:0] column_offset;
        logic [15:0] row_offset;
        logic [23:0] window_opcodes;
    } cfg_t;

    typedef struct packed {
        job_mode_t   mode;
        logic        kind;
        logic [3:0]  nwords;
        logic [7:0]  col_op;
        logic [7:0]  row_op;
        logic [7:0]  ram_op;
        logic [15:0] v0;
        logic [15:0] v1;
        logic [15:0] v2;
        logic [15:0] v3;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef logic [7:0] lut32_t [32];
    typedef logic [7:0] lut64_t [64];

    function automatic lut32_t build_lut5();
        lut32_t lut;
        for (int i = 0; i < 32; i++) begin
            lut[i] = 8'((i * 255) / 31);
        end
        return lut;
    endfunction

    function automatic lut64_t build_lut6();
        lut64_t lut;
        for (int i = 0; i < 64; i++) begin
            lut[i] = 8'((i * 255) / 63);
        end
        return lut;
    endfunction

    localparam lut32_t EXPAND5 = build_lut5();
    localparam lut64_t EXPAND6 = build_lut6();

endpackage

/* rtl/lpw_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// lpw_front
// Accepts drawing requests, computes window coordinates or pixel bus words, and
// pushes one job description into the queue.
// ============================================================================
module lpw_front
    import lpw_pkg::*;
(
    input  logic        start,
    input  logic        busy,
    input  logic        cmd,
    input  logic [15:0] start_x,
    input  logic [15:0] start_y,
    input  logic [15:0] width,
    input  logic [15:0] height,
    input  logic [15:0] color,
    input  cfg_t        cfg,
    output logic        push,
    output job_t        job
);

    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] x2;
    logic [15:0] y2;
    logic        swap;
    logic        ram_send;
    logic [3:0]  win_words;

    assign push = start && !busy;

    always_comb
    begin
        x        = start_x + cfg.column_offset;
        y        = start_y + cfg.row_offset;
        x2       = x + width - 16'd1;
        y2       = y + height - 16'd1;
        swap     = cfg.byte_coordinate_mode && cfg.rotation[0];
        ram_send = (cfg.window_opcodes[23:16] != SKIP_OPCODE);
        win_words = (cfg.byte_coordinate_mode ? BYTE_WORDS : PACKED_WORDS)
                    + {3'd0, ram_send};

        job        = '0;
        job.col_op = cfg.window_opcodes[7:0];
        job.row_op = cfg.window_opcodes[15:8];
        job.ram_op = cfg.window_opcodes[23:16];
        job.kind   = !cfg.all_command_mode;

        if (cmd_t'(cmd) == CMD_WINDOW)
        begin
            job.mode   = cfg.byte_coordinate_mode ? JOB_BYTE : JOB_PACKED;
            job.nwords = win_words;
            job.v0     = swap ? y : x;
            job.v1     = swap ? y2 : x2;
            job.v2     = swap ? x : y;
            job.v3     = swap ? x2 : y2;
        end
        else if (cfg.pixel_is_18bit)
        begin
            job.mode   = JOB_PIX18;
            job.nwords = 4'd3;
            job.v0     = {8'h00, EXPAND5[color[15:11]]};
            job.v1     = {8'h00, EXPAND6[color[10:5]]};
            job.v2     = {8'h00, EXPAND5[color[4:0]]};
        end
        else if (cfg.bus_is_16bit)
        begin
            job.mode   = JOB_PIX16;
            job.nwords = 4'd1;
            job.v0     = color;
        end
        else
        begin
            job.mode   = JOB_PIX8;
            job.nwords = 4'd2;
            job.v0     = {8'h00, color[15:8]};
            job.v1     = {8'h00, color[7:0]};
        end
    end

endmodule

/* rtl/lpw_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// lpw_queue
// Short first-in first-out queue of job descriptions between the front and
// the bus sequencer.
// ============================================================================
module lpw_queue
    import lpw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output job_t          head_job,
    output queue_status_t status
);

    job_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        head_job     = entry_reg[rd_ptr_reg];
        status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
        status.empty = (count_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/lpw_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// lpw_back
// Bus sequencer: takes jobs from the queue and sends their bus words, one
// word per clock, through a registered output.
// ============================================================================
module lpw_back
    import lpw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  job_t          head_job,
    input  queue_status_t status,
    input  logic          bus_is_16bit,
    output logic          pop,
    output logic          strobe,
    output logic          is_data,
    output logic [15:0]   bus_value,
    output logic          wide_cycle,
    output logic          last
);

    job_t        job_reg;
    job_t        job_next;
    logic        active_reg;
    logic        active_next;
    logic [3:0]  idx_reg;
    logic [3:0]  idx_next;
    logic        strobe_reg;
    logic        strobe_next;
    logic        is_data_reg;
    logic        is_data_next;
    logic [15:0] bus_value_reg;
    logic [15:0] bus_value_next;
    logic        wide_cycle_reg;
    logic        wide_cycle_next;
    logic        last_reg;
    logic        last_next;
    logic        last_word;

    always_comb
    begin
        last_word = active_reg && (idx_reg == job_reg.nwords - 4'd1);
        pop       = !status.empty && (!active_reg || last_word);

        active_next = pop || (active_reg && !last_word);
        job_next    = pop ? head_job : job_reg;
        if (pop)
        begin
            idx_next = '0;
        end
        else if (active_reg)
        begin
            idx_next = idx_reg + 4'd1;
        end
        else
        begin
            idx_next = idx_reg;
        end

        strobe_next     = active_reg;
        last_next       = last_word;
        wide_cycle_next = bus_is_16bit;
        is_data_next    = 1'b1;
        bus_value_next  = '0;

        unique case (job_reg.mode)
            JOB_PACKED:
            begin
                case (idx_reg)
                    4'd0:
                    begin
                        is_data_next   = 1'b0;
                        bus_value_next = {8'h00, job_reg.col_op};
                    end
                    4'd1: bus_value_next = {8'h00, job_reg.v0[15:8]};
                    4'd2: bus_value_next = {8'h00, job_reg.v0[7:0]};
                    4'd3: bus_value_next = {8'h00, job_reg.v1[15:8]};
                    4'd4: bus_value_next = {8'h00, job_reg.v1[7:0]};
                    4'd5:
                    begin
                        is_data_next   = 1'b0;
                        bus_value_next = {8'h00, job_reg.row_op};
                    end
                    4'd6: bus_value_next = {8'h00, job_reg.v2[15:8]};
                    4'd7: bus_value_next = {8'h00, job_reg.v2[7:0]};
                    4'd8: bus_value_next = {8'h00, job_reg.v3[15:8]};
                    4'd9: bus_value_next = {8'h00, job_reg.v3[7:0]};
                    default:
                    begin
                        is_data_next   = 1'b0;
                        bus_value_next = {8'h00, job_reg.ram_op};
                    end
                endcase
            end
            JOB_BYTE:
            begin
                is_data_next = job_reg.kind;
                case (idx_reg)
                    4'd0:
                    begin
                        is_data_next   = 1'b0;
                        bus_value_next = {8'h00, job_reg.col_op};
                    end
                    4'd1: bus_value_next = {8'h00, job_reg.v0[7:0]};
                    4'd2: bus_value_next = {8'h00, job_reg.v1[7:0]};
                    4'd3:
                    begin
                        is_data_next   = 1'b0;
                        bus_value_next = {8'h00, job_reg.row_op};
                    end
                    4'd4: bus_value_next = {8'h00, job_reg.v2[7:0]};
                    4'd5: bus_value_next = {8'h00, job_reg.v3[7:0]};
                    default:
                    begin
                        is_data_next   = 1'b0;
                        bus_value_next = {8'h00, job_reg.ram_op};
                    end
                endcase
            end
            JOB_PIX16, JOB_PIX8, JOB_PIX18:
            begin
                case (idx_reg)
                    4'd0:    bus_value_next = job_reg.v0;
                    4'd1:    bus_value_next = job_reg.v1;
                    default: bus_value_next = job_reg.v2;
                endcase
            end
            default:
            begin
                bus_value_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        is_data_reg    <= is_data_next;
        bus_value_reg  <= bus_value_next;
        wide_cycle_reg <= wide_cycle_next;
        last_reg       <= last_next;
    end

    assign strobe     = strobe_reg;
    assign is_data    = is_data_reg;
    assign bus_value  = bus_value_reg;
    assign wide_cycle = wide_cycle_reg;
    assign last       = last_reg;

endmodule

/* rtl/lcd_window_and_pixel_bus_writer_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// lcd_window_and_pixel_bus_writer_top
// Turns window and pixel requests into command and data cycles for an
// 8080-style parallel LCD bus.
// ============================================================================
// A request is taken when start is high and busy is low; busy rises only
// while the four-entry job queue is full. With the sequencer idle, a taken
// request passes through the queue entry, the sequencer's job register and
// the registered output before its first bus word is driven. The sequencer
// then sends one bus word per clock, marked by strobe for a single cycle,
// with last on the final word of each request. A window request sends six
// to eleven bus words and a pixel one to three, so the sustained rate is
// set by the one-word-per-clock bus sequencer. The receiver cannot stall the
// output: every strobed word must be taken in its cycle. The user must write
// configuration registers through cfg_write, cfg_index and cfg_data only
// while no request is in flight; the block itself does not enforce this.
module lcd_window_and_pixel_bus_writer_top
    import lpw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  logic                   cmd,
    input  logic [15:0]            start_x,
    input  logic [15:0]            start_y,
    input  logic [15:0]            width,
    input  logic [15:0]            height,
    input  logic [15:0]            color,
    output logic                   strobe,
    output logic                   is_data,
    output logic [15:0]            bus_value,
    output logic                   wide_cycle,
    output logic                   last
);

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    logic          push;
    job_t          push_job;
    job_t          head_job;
    logic          pop;
    queue_status_t status;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BUS_16BIT:      cfg_next.bus_is_16bit         = cfg_data[0];
                REG_PIXEL_18BIT:    cfg_next.pixel_is_18bit       = cfg_data[0];
                REG_BYTE_COORD:     cfg_next.byte_coordinate_mode = cfg_data[0];
                REG_ALL_COMMAND:    cfg_next.all_command_mode     = cfg_data[0];
                REG_ROTATION:       cfg_next.rotation             = cfg_data[1:0];
                REG_COLUMN_OFFSET:  cfg_next.column_offset        = cfg_data[15:0];
                REG_ROW_OFFSET:     cfg_next.row_offset           = cfg_data[15:0];
                REG_WINDOW_OPCODES: cfg_next.window_opcodes       = cfg_data[23:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{bus_is_16bit:         1'b0,
                         pixel_is_18bit:       1'b0,
                         byte_coordinate_mode: 1'b0,
                         all_command_mode:     1'b0,
                         rotation:             2'd0,
                         column_offset:        16'h0000,
                         row_offset:           16'h0000,
                         window_opcodes:       24'hFFFFFF};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign busy = status.full;

    lpw_front u_front (
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .start_x (start_x),
        .start_y (start_y),
        .width   (width),
        .height  (height),
        .color   (color),
        .cfg     (cfg_reg),
        .push    (push),
        .job     (push_job)
    );

    lpw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (status)
    );

    lpw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_job     (head_job),
        .status       (status),
        .bus_is_16bit (cfg_reg.bus_is_16bit),
        .pop          (pop),
        .strobe       (strobe),
        .is_data      (is_data),
        .bus_value    (bus_value),
        .wide_cycle   (wide_cycle),
        .last         (last)
    );

endmodule
